// ----- rtl/msq_pkg.sv -----
package msq_pkg;

  // Field widths of the input and result items.
  localparam int NOTE_W   = 8;
  localparam int DUR_W    = 10;
  localparam int VOL_W    = 7;
  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int NOTE_IDX_W = 7;
  localparam int NUM_NOTES  = 128;

  // Saturation limits and scaling.
  localparam logic [NOTE_W-1:0] MAX_NOTE        = 8'd127;
  localparam logic [VOL_W-1:0]  MAX_VOLUME      = 7'd100;
  localparam logic [7:0]        AMP_PER_PERCENT = 8'd180;

  // Semitone ratios in Q20, up and down.
  localparam logic [63:0] SEMI_UP_Q20   = 64'd1110928;
  localparam logic [63:0] SEMI_DOWN_Q20 = 64'd989724;
  localparam logic [63:0] ROUND_Q20     = 64'd1 << 19;

  // Item kinds.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } mode_t;

  typedef logic [63:0] step_tab_t [NUM_NOTES];

  // Builds the per-note phase increment table at elaboration. The twelve
  // semitones of octave zero are chained from the A anchor, and each octave
  // above doubles the value. Entries keep 64 bits; the caller takes the
  // phase width it needs.
  function automatic step_tab_t step_table(input logic [63:0] anchor, input int phase_bits);
    step_tab_t   tab;
    logic [63:0] semi_x [12];
    int          n;
    semi_x[9] = anchor;
    for (int s = 10; s < 12; s++) begin
      semi_x[s] = (semi_x[s-1] * SEMI_UP_Q20 + ROUND_Q20) >> 20;
    end
    for (int s = 8; s >= 0; s--) begin
      semi_x[s] = (semi_x[s+1] * SEMI_DOWN_Q20 + ROUND_Q20) >> 20;
    end
    n = 0;
    for (int oct = 0; oct < 11; oct++) begin
      for (int s = 0; s < 12; s++) begin
        if (n < NUM_NOTES) begin
          tab[n] = (semi_x[s] << oct) >> (48 - phase_bits);
        end
        n++;
      end
    end
    return tab;
  endfunction

endpackage

// ----- rtl/msq_in_if.sv -----
interface msq_in_if
  import msq_pkg::*;
;
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [NOTE_W-1:0] note;
  logic [DUR_W-1:0]  duration_ms;
  logic [VOL_W-1:0]  volume;

  modport source (output valid, output mode, output note, output duration_ms,
                  output volume, input ready);
  modport sink   (input valid, input mode, input note, input duration_ms,
                  input volume, output ready);
endinterface

// ----- rtl/msq_out_if.sv -----
interface msq_out_if
  import msq_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last;

  modport source (output valid, output left_sample, output right_sample, output last,
                  input ready);
  modport sink   (input valid, input left_sample, input right_sample, input last,
                  output ready);
endinterface

// ----- rtl/midi_square_tone_generator.sv -----
// Square-wave tone generator driven by MIDI notes. A start item (mode 0)
// loads the note's phase increment from a constant equal-temperament table,
// sets the amplitude to volume * 180 and arms SAMPLES_PER_MS * duration
// samples; note, duration and volume saturate to 127, 1..MAX_DURATION_MS and
// 100. Each tick item (mode 1) while a tone plays yields one stereo sample,
// +amplitude while the phase top bit is clear and -amplitude when set, with
// last high on the final sample. Ticks while idle and start items yield no
// result. The state and the output register are updated at the edge that
// accepts an item, so one item is taken per clock while the output side
// keeps up; a result waiting in the output register holds the input off
// until it is taken.
module midi_square_tone_generator
  import msq_pkg::*;
#(
  parameter int SAMPLES_PER_MS  = 8,
  parameter int MAX_DURATION_MS = 400,
  parameter int PHASE_BITS      = 32
) (
  input  logic clk,
  input  logic rst_n,
  msq_in_if.sink    in_item,
  msq_out_if.source out_item
);

  localparam int DURW  = $clog2(MAX_DURATION_MS + 1);
  localparam int CNT_W = $clog2(SAMPLES_PER_MS * MAX_DURATION_MS + 1);
  localparam logic [63:0] ANCHOR =
      (64'd1 << 48) * 64'd11 / (64'd800 * 64'(SAMPLES_PER_MS));
  localparam step_tab_t STEP_TAB = step_table(ANCHOR, PHASE_BITS);

  logic [PHASE_BITS-1:0]      phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0]      phase_step_r, phase_step_nxt;
  logic [CNT_W-1:0]           samples_left_r, samples_left_nxt;
  logic [AMP_W-1:0]           amplitude_r, amplitude_nxt;
  logic                       tone_active_r, tone_active_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                  in_accept;
  logic [NOTE_IDX_W-1:0] note_sat;
  logic [DURW-1:0]       dur_sat;
  logic [VOL_W-1:0]      vol_sat;
  logic [AMP_W-1:0]      amp_new;
  logic [CNT_W-1:0]      count_new;
  logic [AMP_W:0]        amp_ext;

  // Input is taken whenever the output register is empty or being emptied.
  assign in_item.ready = !out_valid_r || out_item.ready;
  assign in_accept     = in_item.valid && in_item.ready;

  // Saturate the start fields.
  always_comb begin
    if (in_item.note > MAX_NOTE) begin
      note_sat = MAX_NOTE[NOTE_IDX_W-1:0];
    end else begin
      note_sat = in_item.note[NOTE_IDX_W-1:0];
    end
    if (in_item.duration_ms == '0) begin
      dur_sat = DURW'(1);
    end else if (32'(in_item.duration_ms) > 32'(MAX_DURATION_MS)) begin
      dur_sat = DURW'(MAX_DURATION_MS);
    end else begin
      dur_sat = DURW'(in_item.duration_ms);
    end
    if (in_item.volume > MAX_VOLUME) begin
      vol_sat = MAX_VOLUME;
    end else begin
      vol_sat = in_item.volume;
    end
  end

  assign amp_new   = AMP_W'(vol_sat) * AMP_W'(AMP_PER_PERCENT);
  assign count_new = CNT_W'(dur_sat * CNT_W'(SAMPLES_PER_MS));
  assign amp_ext   = {1'b0, amplitude_r};

  // Next state: a start reloads the tone, an active tick emits a sample.
  always_comb begin
    phase_acc_nxt    = phase_acc_r;
    phase_step_nxt   = phase_step_r;
    samples_left_nxt = samples_left_r;
    amplitude_nxt    = amplitude_r;
    tone_active_nxt  = tone_active_r;
    out_valid_nxt    = out_valid_r && !out_item.ready;
    out_sample_nxt   = out_sample_r;
    out_last_nxt     = out_last_r;
    if (in_accept) begin
      if (in_item.mode == MODE_START) begin
        phase_step_nxt   = STEP_TAB[note_sat][PHASE_BITS-1:0];
        phase_acc_nxt    = '0;
        amplitude_nxt    = amp_new;
        samples_left_nxt = count_new;
        tone_active_nxt  = 1'b1;
      end else if (tone_active_r) begin
        if (phase_acc_r[PHASE_BITS-1]) begin
          out_sample_nxt = -$signed(amp_ext);
        end else begin
          out_sample_nxt = $signed(amp_ext);
        end
        phase_acc_nxt    = phase_acc_r + phase_step_r;
        samples_left_nxt = samples_left_r - CNT_W'(1);
        out_valid_nxt    = 1'b1;
        out_last_nxt     = (samples_left_r == CNT_W'(1));
        tone_active_nxt  = (samples_left_r != CNT_W'(1));
      end
    end
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      phase_step_r   <= '0;
      samples_left_r <= '0;
      amplitude_r    <= '0;
      tone_active_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_acc_r    <= phase_acc_nxt;
      phase_step_r   <= phase_step_nxt;
      samples_left_r <= samples_left_nxt;
      amplitude_r    <= amplitude_nxt;
      tone_active_r  <= tone_active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.left_sample  = out_sample_r;
  assign out_item.right_sample = out_sample_r;
  assign out_item.last         = out_last_r;

`ifndef ASSERT_OFF
  // A playing tone always has samples still to come.
  a_active_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    tone_active_r |-> (samples_left_r != '0))
    else $error("active tone with no samples left");

  // The final sample ends the tone.
  a_last_ends_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !tone_active_r)
    else $error("tone still active after last sample");

  // A tick while idle produces nothing.
  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.mode == MODE_TICK && !tone_active_r) |=> !out_valid_r)
    else $error("result produced by idle tick");

  // A start arms the tone at phase zero.
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.mode == MODE_START) |=> (tone_active_r && phase_acc_r == '0))
    else $error("start did not arm the tone");
`endif

endmodule
